// ===== rtl/lfd_pkg.sv =====
package lfd_pkg;

  localparam logic [7:0] HeadByte   = 8'hA3;
  localparam logic [7:0] RespPad    = 8'd10;
  localparam logic [7:0] PlainPad   = 8'd9;
  localparam logic [7:0] RespNeed   = 8'd9;
  localparam logic [7:0] PlainNeed  = 8'd8;
  localparam logic [7:0] PosMax     = 8'd255;
  localparam logic [5:0] CmdMask    = 6'h3F;
  localparam logic [1:0] RespMask   = 2'h3;

  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_HDR = 3'd1,
    ST_BAD_SUM = 3'd2,
    ST_NEG_LEN = 3'd3,
    ST_SHORT   = 3'd4
  } lfd_status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] message_id;
    logic [7:0]  group_code;
    logic [5:0]  command_code;
    logic        is_response;
    logic [7:0]  response_code;
    logic [7:0]  payload_length;
    lfd_status_e status;
    logic        frame_done;
  } lfd_result_t;

  typedef struct packed {
    logic        valid;
    lfd_result_t data;
  } lfd_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lfd_q_status_t;

endpackage

// ===== rtl/lfd_front.sv =====
module lfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  lfd_pkg::lfd_q_status_t q_status_i,
  output lfd_pkg::lfd_push_t   push_o
);
  import lfd_pkg::*;

  logic [7:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [7:0]  len_q, len_d;
  logic [31:0] id_q, id_d;
  logic [7:0]  grp_q, grp_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  rsp_q, rsp_d;
  logic [7:0]  pcnt_q, pcnt_d;

  logic        accept;
  logic        resp;
  logic [7:0]  pad;
  logic        neg;
  logic [7:0]  plen;
  logic        hdr;
  logic [7:0]  need;
  lfd_status_e status;
  lfd_result_t res;
  logic        emit;

  assign stall_o = q_status_i.full;
  assign accept  = valid_i && !q_status_i.full;

  assign resp = ((cmd_q[7:6] & RespMask) != 2'd0);
  assign pad  = resp ? RespPad : PlainPad;
  assign neg  = (len_q < pad);
  assign plen = neg ? 8'd0 : (len_q - pad);
  assign hdr  = (pos_q == 8'd0) ? (data_byte_i == HeadByte) : hdr_ok_q;
  assign need = resp ? RespNeed : PlainNeed;

  // Summary status in priority order
  always_comb begin
    if (!hdr) begin
      status = ST_BAD_HDR;
    end else if (sum_q != data_byte_i) begin
      status = ST_BAD_SUM;
    end else if (pos_q < need) begin
      status = ST_SHORT;
    end else if (neg) begin
      status = ST_NEG_LEN;
    end else if (pcnt_q < plen) begin
      status = ST_SHORT;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    hdr_ok_d = hdr_ok_q;
    len_d    = len_q;
    id_d     = id_q;
    grp_d    = grp_q;
    cmd_d    = cmd_q;
    rsp_d    = rsp_q;
    pcnt_d   = pcnt_q;
    emit     = 1'b0;
    res      = '0;

    if (accept) begin
      if (last_byte_i) begin
        emit               = 1'b1;
        res.kind           = 1'b1;
        res.message_id     = id_q;
        res.group_code     = grp_q;
        res.command_code   = cmd_q[5:0] & CmdMask;
        res.is_response    = resp;
        res.response_code  = resp ? rsp_q : 8'd0;
        res.payload_length = plen;
        res.status         = status;
        res.frame_done     = 1'b1;
        // back to the idle frame state
        pos_d    = '0;
        sum_d    = '0;
        hdr_ok_d = 1'b0;
        len_d    = '0;
        id_d     = '0;
        grp_d    = '0;
        cmd_d    = '0;
        rsp_d    = '0;
        pcnt_d   = '0;
      end else begin
        if (pos_q == 8'd0) begin
          hdr_ok_d = (data_byte_i == HeadByte);
        end else if (pos_q == 8'd1) begin
          len_d = data_byte_i;
        end else if (pos_q <= 8'd5) begin
          id_d = {id_q[23:0], data_byte_i};
        end else if (pos_q == 8'd6) begin
          grp_d = data_byte_i;
        end else if (pos_q == 8'd7) begin
          cmd_d = data_byte_i;
        end else if (pos_q == 8'd8 && resp) begin
          rsp_d = data_byte_i;
        end else if (hdr_ok_q && !neg && (pcnt_q < plen)) begin
          pcnt_d           = pcnt_q + 8'd1;
          emit             = 1'b1;
          res.kind         = 1'b0;
          res.payload_byte = data_byte_i;
        end
        sum_d = sum_q + data_byte_i;
        if (pos_q != PosMax) begin
          pos_d = pos_q + 8'd1;
        end
      end
    end
  end

  assign push_o.valid = emit;
  assign push_o.data  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      hdr_ok_q <= 1'b0;
      len_q    <= '0;
      id_q     <= '0;
      grp_q    <= '0;
      cmd_q    <= '0;
      rsp_q    <= '0;
      pcnt_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      hdr_ok_q <= hdr_ok_d;
      len_q    <= len_d;
      id_q     <= id_d;
      grp_q    <= grp_d;
      cmd_q    <= cmd_d;
      rsp_q    <= rsp_d;
      pcnt_q   <= pcnt_d;
    end
  end

endmodule

// ===== rtl/lfd_queue.sv =====
module lfd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfd_pkg::lfd_push_t    push_i,
  input  logic                  pop_i,
  output lfd_pkg::lfd_result_t  head_o,
  output lfd_pkg::lfd_q_status_t status_o
);
  import lfd_pkg::*;

  lfd_result_t            mem_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;
  logic                   do_push;
  logic                   do_pop;

  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i.valid && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/lfd_back.sv =====
module lfd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lfd_pkg::lfd_q_status_t q_status_i,
  input  lfd_pkg::lfd_result_t   q_head_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  logic                   stall_i,
  output lfd_pkg::lfd_result_t   result_o
);
  import lfd_pkg::*;

  logic        valid_q, valid_d;
  lfd_result_t res_q;
  logic        load;

  // Refill the output register whenever it is empty or being taken and the queue holds a result
  assign load    = (!valid_q || !stall_i) && !q_status_i.empty;
  assign pop_o   = load;
  assign valid_d = load ? 1'b1 : (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= q_head_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ===== rtl/led_frame_deframer.sv =====
// Byte-wise deframer for LED control frames.
// Input channel: one frame byte per request on data_byte_i, with last_byte_i
// marking the closing checksum byte; a request is taken when valid_i is high
// and stall_o is low. Output channel: one result per request taken on
// valid_o / stall_i. kind_o = 0 carries a payload byte, kind_o = 1 is the
// end-of-frame summary with the header fields and status_o (frame_done_o set).
// Header, id, group and command bytes produce no result.
// Throughput: one byte per cycle, whatever mix of results, while the result
// queue is not full. A result is written into the queue at the edge that
// takes its byte and loaded into the output register once that is free.
// A two-entry result queue sits between the byte classifier and the output
// register; when the receiver stalls the queue fills and stall_o rises once
// it is full, so no result is lost or repeated.
// Reset clears the frame state, empties the queue and drops valid_o; stall_o
// is low straight out of reset, so the block takes bytes at once.
module led_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] message_id_o,
  output logic [7:0]  group_code_o,
  output logic [5:0]  command_code_o,
  output logic        is_response_o,
  output logic [7:0]  response_code_o,
  output logic [7:0]  payload_length_o,
  output logic [2:0]  status_o,
  output logic        frame_done_o
);
  import lfd_pkg::*;

  lfd_push_t     push;
  lfd_q_status_t q_status;
  lfd_result_t   q_head;
  logic          pop;
  lfd_result_t   result;

  lfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_status_i  (q_status),
    .push_o      (push)
  );

  lfd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  lfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_head_i   (q_head),
    .pop_o      (pop),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .result_o   (result)
  );

  assign kind_o           = result.kind;
  assign payload_byte_o   = result.payload_byte;
  assign message_id_o     = result.message_id;
  assign group_code_o     = result.group_code;
  assign command_code_o   = result.command_code;
  assign is_response_o    = result.is_response;
  assign response_code_o  = result.response_code;
  assign payload_length_o = result.payload_length;
  assign status_o         = result.status;
  assign frame_done_o     = result.frame_done;

endmodule

// ===== dv/led_frame_deframer_tb.sv =====
`timescale 1ns / 1ps

module led_frame_deframer_tb;
  import lfd_pkg::*;

  localparam int unsigned RandomBytes = 450;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned TailCycles  = 10;

  // Tracks the frame as the block sees it and holds the results it owes.
  class deframe_tracker;
    logic [7:0]  pos, sum, len, group, cmd, resp_code, pay_cnt;
    logic        hdr_ok;
    logic [31:0] id;
    lfd_result_t expected_results[$];
    int unsigned errors, bytes_in, payloads, summaries;
    int unsigned status_hits[5];

    function new();
      clear();
    endfunction

    function void clear();
      pos = '0;
      sum = '0;
      len = '0;
      group = '0;
      cmd = '0;
      resp_code = '0;
      pay_cnt = '0;
      hdr_ok = 1'b0;
      id = '0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      lfd_result_t r;
      logic        resp, neg;
      logic [7:0]  pad, plen;
      r = '0;
      bytes_in++;
      resp = (cmd[7:6] & RespMask) != 2'b00;
      pad = resp ? RespPad : PlainPad;
      neg = len < pad;
      plen = neg ? 8'd0 : len - pad;
      if (last) begin
        r.kind = 1'b1;
        r.message_id = id;
        r.group_code = group;
        r.command_code = cmd[5:0] & CmdMask;
        r.is_response = resp;
        r.response_code = resp ? resp_code : 8'd0;
        r.payload_length = plen;
        r.frame_done = 1'b1;
        // the lone byte of a one-byte frame is judged as the header too
        if ((pos == 8'd0) ? (b != HeadByte) : !hdr_ok) r.status = ST_BAD_HDR;
        else if (sum != b) r.status = ST_BAD_SUM;
        else if (pos < (resp ? RespNeed : PlainNeed)) r.status = ST_SHORT;
        else if (neg) r.status = ST_NEG_LEN;
        else if (pay_cnt < plen) r.status = ST_SHORT;
        else r.status = ST_OK;
        expected_results.push_back(r);
        summaries++;
        status_hits[r.status]++;
        clear();
        return;
      end
      if (pos == 8'd0) hdr_ok = (b == HeadByte);
      else if (pos == 8'd1) len = b;
      else if (pos <= 8'd5) id = {id[23:0], b};
      else if (pos == 8'd6) group = b;
      else if (pos == 8'd7) cmd = b;
      else if (pos == 8'd8 && resp) resp_code = b;
      else if (hdr_ok && !neg && pay_cnt < plen) begin
        pay_cnt++;
        r.payload_byte = b;
        expected_results.push_back(r);
        payloads++;
      end
      sum += b;
      if (pos != PosMax) pos++;
    endfunction

    function void field_eq(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(lfd_result_t got);
      lfd_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", got.kind);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      field_eq("kind", 32'(want.kind), 32'(got.kind));
      field_eq("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      field_eq("message_id", want.message_id, got.message_id);
      field_eq("group_code", 32'(want.group_code), 32'(got.group_code));
      field_eq("command_code", 32'(want.command_code), 32'(got.command_code));
      field_eq("is_response", 32'(want.is_response), 32'(got.is_response));
      field_eq("response_code", 32'(want.response_code), 32'(got.response_code));
      field_eq("payload_length", 32'(want.payload_length), 32'(got.payload_length));
      field_eq("status", 32'(want.status), 32'(got.status));
      field_eq("frame_done", 32'(want.frame_done), 32'(got.frame_done));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        valid_o;
  logic        stall_i;
  logic        kind_o;
  logic [7:0]  payload_byte_o;
  logic [31:0] message_id_o;
  logic [7:0]  group_code_o;
  logic [5:0]  command_code_o;
  logic        is_response_o;
  logic [7:0]  response_code_o;
  logic [7:0]  payload_length_o;
  logic [2:0]  status_o;
  logic        frame_done_o;

  deframe_tracker tracker;
  logic [7:0]     frame_bytes[$];
  bit             calm;
  int unsigned    quiet_cycles;
  int unsigned    random_sent;
  int unsigned    frame_idx;

  led_frame_deframer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .message_id_o     (message_id_o),
    .group_code_o     (group_code_o),
    .command_code_o   (command_code_o),
    .is_response_o    (is_response_o),
    .response_code_o  (response_code_o),
    .payload_length_o (payload_length_o),
    .status_o         (status_o),
    .frame_done_o     (frame_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    stall_i <= !calm && ($urandom_range(99) < 20);
  end

  always @(posedge clk_i) begin
    lfd_result_t got;
    if (rst_ni) begin
      if (valid_i && !stall_o) tracker.take_byte(data_byte_i, last_byte_i);
      if (valid_o && !stall_i) begin
        got.kind = kind_o;
        got.payload_byte = payload_byte_o;
        got.message_id = message_id_o;
        got.group_code = group_code_o;
        got.command_code = command_code_o;
        got.is_response = is_response_o;
        got.response_code = response_code_o;
        got.payload_length = payload_length_o;
        got.status = lfd_status_e'(status_o);
        got.frame_done = frame_done_o;
        tracker.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("led_frame_deframer_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 20) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  // Append the checksum, optionally spoilt by flip, and send the whole frame.
  task automatic close_and_send(input logic [7:0] flip);
    logic [7:0] sum;
    sum = '0;
    foreach (frame_bytes[i]) sum += frame_bytes[i];
    frame_bytes.push_back(sum ^ flip);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Mostly well-formed frames with random content; some cut short, padded,
  // misheaded or with a spoilt checksum.
  task automatic build_frame(input bit max_len);
    logic [7:0]  len, cmd, pad, flip;
    bit          resp;
    int unsigned plen, n_pay, cut;
    frame_bytes.delete();
    resp = !max_len && ($urandom_range(99) < 40);
    cmd = 8'($urandom);
    if (resp) begin
      if (cmd[7:6] == 2'b00) cmd[7:6] = 2'($urandom_range(3, 1));
    end else begin
      cmd[7:6] = 2'b00;
    end
    pad = resp ? RespPad : PlainPad;
    if (max_len) len = 8'hFF;
    else if ($urandom_range(99) < 15) len = 8'($urandom);
    else len = pad + 8'($urandom_range(0, 10));
    plen = (len < pad) ? 0 : int'(len - pad);
    n_pay = plen;
    if (max_len) n_pay = plen + 6;
    else if (n_pay > 12) n_pay = $urandom_range(0, 12);
    else if ($urandom_range(99) < 10) n_pay = $urandom_range(0, plen);
    else if ($urandom_range(99) < 10) n_pay = plen + $urandom_range(1, 4);

    frame_bytes.push_back(($urandom_range(99) < 6) ? 8'($urandom) : HeadByte);
    frame_bytes.push_back(len);
    repeat (4) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(cmd);
    if (resp) frame_bytes.push_back(8'($urandom));
    repeat (n_pay) frame_bytes.push_back(8'($urandom));
    if (!max_len && $urandom_range(99) < 10) begin
      cut = $urandom_range(0, resp ? 8 : 7);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    flip = ($urandom_range(99) < 8) ? 8'($urandom_range(1, 255)) : 8'h00;
    close_and_send(flip);
  endtask

  initial begin
    tracker = new();
    rst_ni = 1'b0;
    valid_i = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    stall_i = 1'b0;
    calm = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // one-byte frames: wrong header, then right header that fails the checksum
    frame_bytes = {};
    close_and_send(8'h00);
    frame_bytes = {};
    close_and_send(HeadByte);
    // frame that ends inside the id
    frame_bytes = '{HeadByte, 8'h05, 8'h12};
    close_and_send(8'h00);
    // response frame whose length is below the response padding
    frame_bytes = '{HeadByte, 8'h09, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h00, 8'hFF, 8'h80};
    close_and_send(8'h00);
    // plain frame with one payload byte
    frame_bytes = '{HeadByte, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF};
    close_and_send(8'h00);

    random_sent = 0;
    frame_idx = 0;
    while (random_sent < RandomBytes) begin
      calm = (frame_idx >= 10 && frame_idx < 18);
      build_frame(frame_idx == 4);
      random_sent += frame_bytes.size();
      frame_idx++;
    end
    calm = 1'b0;
    @(negedge clk_i);
    valid_i <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Fed %0d bytes over %0d frames; checked %0d payload bytes and %0d summaries.",
             tracker.bytes_in, tracker.summaries, tracker.payloads, tracker.summaries);
    $display({"Frame endings: ok %0d, bad header %0d, bad checksum %0d, ",
              "negative length %0d, short %0d"},
             tracker.status_hits[ST_OK], tracker.status_hits[ST_BAD_HDR],
             tracker.status_hits[ST_BAD_SUM], tracker.status_hits[ST_NEG_LEN],
             tracker.status_hits[ST_SHORT]);
    if (tracker.errors == 0) begin
      $display("led_frame_deframer_tb passed");
    end else begin
      $display("led_frame_deframer_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lfd_pkg.sv
rtl/lfd_front.sv
rtl/lfd_queue.sv
rtl/lfd_back.sv
rtl/led_frame_deframer.sv
dv/led_frame_deframer_tb.sv
